@@ design/bfds_pkg.sv @@
// ----------------------------------------------------------------------------
// bfds_pkg
// Shared types and constants of the box-filter downscaler: pixel beats,
// register map, field widths and the command and status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package bfds_pkg;

	// Channel and field widths fixed by the pixel format and the register map.
	localparam int PIX_W       = 8;
	localparam int CH_N        = 4;
	localparam int FACTOR_W    = 5;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 13;
	localparam int MAX_HEIGHT  = 4096;

	// Defaults of the module parameters.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_FACTOR_DEF = 16;

	// Register values after reset.
	localparam logic [FACTOR_W-1:0] FACTOR_X_RST   = 5'd2;
	localparam logic [FACTOR_W-1:0] FACTOR_Y_RST   = 5'd2;
	localparam logic [WIDTH_W-1:0]  SRC_WIDTH_RST  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] SRC_HEIGHT_RST = 13'd768;

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_FACTOR_X   = 2'd0;
	localparam reg_idx_t REG_FACTOR_Y   = 2'd1;
	localparam reg_idx_t REG_SRC_WIDTH  = 2'd2;
	localparam reg_idx_t REG_SRC_HEIGHT = 2'd3;

	// Source pixel beat.
	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
		logic [PIX_W-1:0] in_alpha;
	} pixel_in_t;

	// Downscaled pixel beat.
	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_alpha;
		logic             frame_end;
	} pixel_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // source beat taken: latch pixel, read sums, step counters
		logic update;     // write the accumulated sums back
		logic div_start;  // launch the averaging divide
		logic out_load;   // move the quotients into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic blk_done;   // the pixel in hand completes a block
		logic div_done;   // divider idle with its result ready
	} dp_status_t;

endpackage

@@ design/bfds_divider.sv @@
// ----------------------------------------------------------------------------
// bfds_divider
// Four-channel restoring divider. Divides each block sum by the block area,
// one quotient bit per cycle, all channels in parallel against one divisor.
// ----------------------------------------------------------------------------
module bfds_divider import bfds_pkg::*; #(
	parameter int SUM_W = 16,
	parameter int DIV_W = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [CH_N-1:0][SUM_W-1:0]        dividend,
	input  logic [DIV_W-1:0]                  divisor,
	output logic [CH_N-1:0][PIX_W-1:0]        quotient,
	output logic                              done
);

	// The mean of 8-bit samples fits in 8 bits, so the divisor starts
	// shifted up by seven places and only eight trial subtractions are needed.
	localparam int DSH_W = DIV_W + PIX_W - 1;
	localparam int CMP_W = (SUM_W > DSH_W) ? SUM_W : DSH_W;
	localparam int CNT_W = $clog2(PIX_W);

	logic                             busy_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [CMP_W-1:0]                 dsh_q;
	logic [CH_N-1:0][CMP_W-1:0]       rem_q;
	logic [CH_N-1:0][PIX_W-1:0]       quot_q;
	logic [CH_N-1:0][CMP_W-1:0]       rem_nxt;
	logic [CH_N-1:0][PIX_W-1:0]       quot_nxt;

	// One trial subtraction per channel.
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			if (rem_q[c] >= dsh_q) begin
				rem_nxt[c]  = rem_q[c] - dsh_q;
				quot_nxt[c] = {quot_q[c][PIX_W-2:0], 1'b1};
			end else begin
				rem_nxt[c]  = rem_q[c];
				quot_nxt[c] = {quot_q[c][PIX_W-2:0], 1'b0};
			end
		end
	end

	// Sequencing of the eight steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(PIX_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainders, shifted divisor and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			dsh_q <= CMP_W'(divisor) << (PIX_W - 1);
			for (int c = 0; c < CH_N; c++) begin
				rem_q[c] <= CMP_W'(dividend[c]);
			end
		end else if (busy_q) begin
			dsh_q  <= dsh_q >> 1;
			rem_q  <= rem_nxt;
			quot_q <= quot_nxt;
		end
	end

	assign quotient = quot_q;
	assign done     = !busy_q;

endmodule

@@ design/bfds_datapath.sv @@
// ----------------------------------------------------------------------------
// bfds_datapath
// Frame position counters, the column-sum line memory with its
// read-modify-write path, the averaging divider and the output register.
// ----------------------------------------------------------------------------
module bfds_datapath import bfds_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 restart,
	input  logic [$clog2(MAX_FACTOR+1)-1:0]      fx,
	input  logic [$clog2(MAX_FACTOR+1)-1:0]      fy,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]       w,
	input  logic [HEIGHT_W-1:0]                  h,
	input  pixel_in_t                            pixel,
	input  ctrl_cmd_t                            cmd,
	output dp_status_t                           status,
	output pixel_out_t                           result
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int FAC_W  = $clog2(MAX_FACTOR + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = HEIGHT_W;
	localparam int CX_W   = COL_W + FAC_W + 1;
	localparam int RX_W   = ROW_W + FAC_W + 1;
	localparam int SUM_W  = PIX_W + 2 * $clog2(MAX_FACTOR);
	localparam int DIV_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

	// Position within the frame and within the current block.
	logic [COL_W-1:0]  col_q, col_base_q;
	logic [ROW_W-1:0]  row_q, row_base_q;
	logic [FAC_W-1:0]  cib_q, rib_q;

	// Stage one: pixel and decisions taken at acceptance.
	logic                          hit_s1, clr_s1, done_s1, fend_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic [CH_N-1:0][PIX_W-1:0]    pix_s1;
	logic [CH_N-1:0][SUM_W-1:0]    rd_s1;

	logic [CH_N-1:0][SUM_W-1:0]    mem_q [MAX_WIDTH];
	logic [CH_N-1:0][SUM_W-1:0]    sum_new;
	logic [CH_N-1:0][PIX_W-1:0]    quot;
	logic [DIV_W-1:0]              area;
	logic                          div_done;

	logic col_in, row_in, col_last, row_last, hit, clr, blk_end;
	logic cib_more, rib_more, row_wrap, frame_wrap;

	// Block membership from the block origin: a block is whole when it fits
	// inside the image, and it is the last one when the next would not.
	always_comb begin
		col_in   = (CX_W'(col_base_q) + CX_W'(fx)) <= CX_W'(w);
		row_in   = (RX_W'(row_base_q) + RX_W'(fy)) <= RX_W'(h);
		col_last = (CX_W'(col_base_q) + (CX_W'(fx) << 1)) > CX_W'(w);
		row_last = (RX_W'(row_base_q) + (RX_W'(fy) << 1)) > RX_W'(h);
		hit      = col_in && row_in;
		clr      = (cib_q == '0) && (rib_q == '0);
		blk_end  = ((FAC_W+1)'(cib_q) + 1'b1 == (FAC_W+1)'(fx)) &&
		           ((FAC_W+1)'(rib_q) + 1'b1 == (FAC_W+1)'(fy));
		cib_more = col_in && ((FAC_W+1)'(cib_q) + 1'b1 < (FAC_W+1)'(fx));
		rib_more = row_in && ((FAC_W+1)'(rib_q) + 1'b1 < (FAC_W+1)'(fy));
		row_wrap = (CX_W'(col_q) + 1'b1) >= CX_W'(w);
		frame_wrap = (RX_W'(row_q) + 1'b1) >= RX_W'(h);
	end

	// Raster position counters, stepped once for every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			col_base_q <= '0;
			cib_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			rib_q      <= '0;
		end else if (restart) begin
			col_q      <= '0;
			col_base_q <= '0;
			cib_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			rib_q      <= '0;
		end else if (cmd.accept) begin
			if (row_wrap) begin
				col_q      <= '0;
				col_base_q <= '0;
				cib_q      <= '0;
				if (frame_wrap) begin
					row_q      <= '0;
					row_base_q <= '0;
					rib_q      <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					if (rib_more) begin
						rib_q <= rib_q + 1'b1;
					end else begin
						rib_q      <= '0;
						row_base_q <= row_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
				if (cib_more) begin
					cib_q <= cib_q + 1'b1;
				end else begin
					cib_q      <= '0;
					col_base_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Decision flags of the beat in hand.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1  <= 1'b0;
			clr_s1  <= 1'b0;
			done_s1 <= 1'b0;
			fend_s1 <= 1'b0;
		end else if (cmd.accept) begin
			hit_s1  <= hit;
			clr_s1  <= clr;
			done_s1 <= blk_end;
			fend_s1 <= col_last && row_last;
		end
	end

	// Pixel capture and line memory read at the block origin.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_s1   <= col_base_q[ADDR_W-1:0];
			pix_s1[0] <= pixel.in_red;
			pix_s1[1] <= pixel.in_green;
			pix_s1[2] <= pixel.in_blue;
			pix_s1[3] <= pixel.in_alpha;
			rd_s1     <= mem_q[col_base_q[ADDR_W-1:0]];
		end
	end

	// Accumulate; the first pixel of a block in a new block row starts afresh.
	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			sum_new[c] = (clr_s1 ? '0 : rd_s1[c]) + SUM_W'(pix_s1[c]);
		end
	end

	// Line memory write-back.
	always_ff @(posedge clk) begin
		if (cmd.update && hit_s1) begin
			mem_q[addr_s1] <= sum_new;
		end
	end

	assign area = DIV_W'(fx) * DIV_W'(fy);

	bfds_divider #(
		.SUM_W (SUM_W),
		.DIV_W (DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_new),
		.divisor  (area),
		.quotient (quot),
		.done     (div_done)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result.out_red   <= quot[0];
			result.out_green <= quot[1];
			result.out_blue  <= quot[2];
			result.out_alpha <= quot[3];
			result.frame_end <= fend_s1;
		end
	end

	assign status.blk_done = hit_s1 && done_s1;
	assign status.div_done = div_done;

endmodule

@@ design/bfds_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfds_ctrl
// Controller of the downscaler: takes a source beat, sequences the sum
// write-back and the divide, and owns the output valid flag.
// ----------------------------------------------------------------------------
module bfds_ctrl import bfds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	output logic       dst_valid,
	input  logic       dst_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_UPDATE = 3'b010,
		ST_DIV    = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// The output register can be refilled when empty or being emptied.
	assign out_free = !out_valid_q || !dst_stall;

	// Next state and commands.
	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (status.blk_done) begin
					cmd.div_start = 1'b1;
					state_nxt     = ST_DIV;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (status.div_done && out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = out_valid_q;

endmodule

@@ design/box_filter_image_downscaler_unit.sv @@
// ----------------------------------------------------------------------------
// box_filter_image_downscaler_unit
// Shrinks an RGBA8888 raster stream by integer factors with a box filter.
// Each output pixel is the truncated per-channel mean of a factor_x by
// factor_y block; columns and rows beyond the last whole block are taken in
// and dropped, and frame_end marks the last output pixel of a frame. A
// source pixel is taken in by a read-modify-write of the column-sum line
// memory; one that completes a block then waits for the eight-step divider
// and a free output register. Any register write restarts the frame at its
// top-left corner; the line memory needs no clearing pass, as each entry is
// restarted by the first pixel of its block.
// ----------------------------------------------------------------------------
module box_filter_image_downscaler_unit import bfds_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Source pixels.
	input  logic                  src_valid,
	output logic                  src_stall,
	input  pixel_in_t             src_pixel,
	// Downscaled pixels.
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output pixel_out_t            dst_pixel,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int FAC_W = $clog2(MAX_FACTOR + 1);
	localparam int COL_W = $clog2(MAX_WIDTH + 1);

	logic [FACTOR_W-1:0] factor_x_q, factor_y_q;
	logic [WIDTH_W-1:0]  src_width_q;
	logic [HEIGHT_W-1:0] src_height_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;
	logic [FAC_W-1:0]    fx_eff, fy_eff;
	logic [COL_W-1:0]    w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	ctrl_cmd_t           cmd;
	dp_status_t          status;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_x_q   <= FACTOR_X_RST;
			factor_y_q   <= FACTOR_Y_RST;
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FACTOR_X:   factor_x_q   <= pwdata[FACTOR_W-1:0];
				REG_FACTOR_Y:   factor_y_q   <= pwdata[FACTOR_W-1:0];
				REG_SRC_WIDTH:  src_width_q  <= pwdata[WIDTH_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_FACTOR_X:   prdata = APB_DATA_W'(factor_x_q);
			REG_FACTOR_Y:   prdata = APB_DATA_W'(factor_y_q);
			REG_SRC_WIDTH:  prdata = APB_DATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = APB_DATA_W'(src_height_q);
			default:        prdata = '0;
		endcase
	end

	// Working values: zero acts as one, anything above the limit as the limit.
	always_comb begin
		if (factor_x_q == '0) begin
			fx_eff = FAC_W'(1);
		end else if (32'(factor_x_q) > 32'(MAX_FACTOR)) begin
			fx_eff = FAC_W'(MAX_FACTOR);
		end else begin
			fx_eff = FAC_W'(factor_x_q);
		end

		if (factor_y_q == '0) begin
			fy_eff = FAC_W'(1);
		end else if (32'(factor_y_q) > 32'(MAX_FACTOR)) begin
			fy_eff = FAC_W'(MAX_FACTOR);
		end else begin
			fy_eff = FAC_W'(factor_y_q);
		end

		if (src_width_q == '0) begin
			w_eff = COL_W'(1);
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = COL_W'(src_width_q);
		end

		if (src_height_q == '0) begin
			h_eff = HEIGHT_W'(1);
		end else if (32'(src_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_W'(MAX_HEIGHT);
		end else begin
			h_eff = src_height_q;
		end
	end

	bfds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bfds_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.fx      (fx_eff),
		.fy      (fy_eff),
		.w       (w_eff),
		.h       (h_eff),
		.pixel   (src_pixel),
		.cmd     (cmd),
		.status  (status),
		.result  (dst_pixel)
	);

endmodule
